FILE: design/dvrt_pkg.sv
// dvrt_pkg: shared types and opcode codes for the distance-vector route table.
// No dependencies.
`timescale 1ns / 1ps
package dvrt_pkg;
    typedef enum logic [2:0] {
        OP_RESET = 3'd0,
        OP_ADD   = 3'd1,
        OP_ROUTE = 3'd2,
        OP_DEAD  = 3'd3,
        OP_DUMP  = 3'd4
    } t_opcode;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    localparam logic [15:0] INF_RESET = 16'd999;
    localparam int MAX_DUMP = 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_OUT,
        S_DUMP
    } t_state;

    typedef struct packed {
        logic [7:0]  dest;
        logic [7:0]  hop;
        logic [15:0] cost;
    } t_entry;

    // Command item, fields in channel order.
    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  src_rtr;
        logic [15:0] link_cost;
        logic [7:0]  dest_id;
        logic [7:0]  adv_hop;
        logic [15:0] route_cost;
        logic [7:0]  dead_neighbor_id;
        logic        last_of_packet;
    } t_cmd_item;

    // Result item, fields in channel order.
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  entry_index;
        logic [7:0]  entry_dest;
        logic [7:0]  entry_hop;
        logic [15:0] entry_cost;
        logic        last_entry;
        logic        route_changed;
        logic        packet_changed;
        logic [4:0]  route_count;
    } t_result_item;

    // Commands broadcast from the controller to all cells.
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_SHIFT,
        CMD_WRITE,
        CMD_KILL
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  match_nh;
        logic [7:0]  match_dest;
        logic        use_dest;
        logic [15:0] cost;
        t_entry      wr_entry;
    } t_cell_cmd;
endpackage

FILE: design/dvrt_if.sv
// dvrt_if: valid/ready channels for command items and result items.
// Depends on dvrt_pkg.
`timescale 1ns / 1ps
interface dvrt_cmd_if ();
    logic                  valid;
    logic                  ready;
    dvrt_pkg::t_cmd_item   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dvrt_res_if ();
    logic                   valid;
    logic                   ready;
    dvrt_pkg::t_result_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/dvrt_cell.sv
// dvrt_cell: one table entry of the rotating cell chain.
// Depends on dvrt_pkg.
`timescale 1ns / 1ps
module dvrt_cell (
    input  logic               i_clk,
    input  logic               i_self_sel,   // this cell is the write target
    input  logic               i_live,       // cell lies below entries_used
    input  dvrt_pkg::t_cell_cmd i_cmd,
    input  dvrt_pkg::t_entry   i_prev,
    output dvrt_pkg::t_entry   o_entry
);
    import dvrt_pkg::*;
    t_entry r_e, n_e;

    always_comb begin
        n_e = r_e;
        case (i_cmd.kind)
            CMD_SHIFT: n_e = i_prev;
            CMD_WRITE: if (i_self_sel) n_e = i_cmd.wr_entry;
            CMD_KILL: begin
                if (i_live && r_e.hop == i_cmd.match_nh &&
                    (!i_cmd.use_dest || r_e.dest == i_cmd.match_dest))
                    n_e.cost = i_cmd.cost;
            end
            default: n_e = r_e;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_e <= n_e;
    end

    assign o_entry = r_e;
endmodule

FILE: design/distance_vector_route_table.sv
// distance_vector_route_table: top level, controller and cell chain.
// Depends on dvrt_pkg, dvrt_if and dvrt_cell.
// Usage:
//  - i_in (sink) takes one command item; o_out (source) returns result items.
//  - The table is a ring of TABLE_DEPTH cells. A route search rotates the ring
//    one full turn, the head cell compared each cycle against the destination
//    and the sender (position 0 skipped); the ring ends back in place.
//  - Dead-neighbor and poison updates act on all live cells at once; poison
//    leaves position 0 alone.
//  - Route item: the ring turns (S_SCAN), the table is updated (S_EXEC) and
//    the result is loaded (S_OUT); the next item waits for its acceptance.
//  - Other non-dump items skip S_SCAN and go through S_EXEC and S_OUT.
//  - Dump: results follow one per cycle while the receiver keeps up; the next
//    item is taken the cycle after the last result is accepted. An empty
//    table dumps nothing and the block is ready again next cycle.
//  - One item is worked at a time; i_in.ready is high only when idle with
//    the output register empty.
//  - A stalled receiver holds the result in the output register; the block
//    waits without losing it and keeps i_in.ready low.
//  - Reset clears entries_used, the packet flag and the config registers
//    (my_router_id 0, infinity_cost 999). Entry contents are undefined until
//    written; there is no clearing pass.
//  - APB registers: 0x0 my_router_id, 0x4 infinity_cost. pready always high.
`timescale 1ns / 1ps
module distance_vector_route_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dvrt_cmd_if.sink    i_in,
    dvrt_res_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dvrt_pkg::*;
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // ---------------- configuration ----------------
    logic [7:0]  r_my_id;
    logic [15:0] r_inf;
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_id <= '0;
            r_inf   <= INF_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == 1'b0) r_my_id <= pwdata[7:0];
            else                  r_inf   <= pwdata[15:0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr[2] == 1'b0) prdata[7:0] = r_my_id;
        else                  prdata[15:0] = r_inf;
    end

    // ---------------- cell chain ----------------
    t_entry    w_e [TABLE_DEPTH];
    t_cell_cmd w_cmd;
    logic [IW-1:0] w_wsel;
    logic [CW-1:0] r_used;
    logic [IW-1:0] r_rot;      // ring offset: cell 0 holds entry r_rot

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            dvrt_cell u_cell (
                .i_clk     (i_clk),
                .i_self_sel(w_wsel == IW'(g)),
                // poisoning never touches position 0
                .i_live    ((CW'(g) < r_used) && !(g == 0 && w_cmd.use_dest)),
                .i_cmd     (w_cmd),
                .i_prev    (w_e[(g + 1) % TABLE_DEPTH]),
                .o_entry   (w_e[g])
            );
        end
    endgenerate

    // ---------------- controller ----------------
    t_state r_st, n_st;
    t_opcode r_op;
    logic [7:0]  r_snd, r_dst, r_anh;
    logic [15:0] r_lc, r_rc;
    logic        r_lastp, r_pflag;
    logic [IW-1:0] r_i;            // found destination position
    logic        r_fi, r_fk;
    t_entry      r_ei, r_ek;
    logic [CW-1:0] r_cnt;          // scan/dump counter
    logic [CW-1:0] r_dn;

    // output register
    logic        r_ov;
    logic [1:0]  r_status;
    logic [3:0]  r_idx;
    logic [7:0]  r_odst, r_onh;
    logic [15:0] r_ocost;
    logic        r_olast, r_ochg, r_opch;
    logic [4:0]  r_ocnt;

    logic [16:0] w_sum;
    logic [15:0] w_nc;
    logic [IW-1:0] w_head_pos;
    logic        w_in_acc, w_out_acc, w_dump_step;
    logic        w_full;
    logic        w_pois_chg;
    logic [1:0]  w_status;
    logic        w_chg;
    logic [CW-1:0] w_used_n;

    assign w_head_pos = r_rot;

    always_comb begin
        w_sum = {1'b0, r_rc} + {1'b0, r_ek.cost};
        if (r_snd == r_dst) w_nc = (r_lc > r_inf) ? r_inf : r_lc;
        else                w_nc = (w_sum > {1'b0, r_inf}) ? r_inf : w_sum[15:0];
    end

    assign i_in.ready = (r_st == S_IDLE) && !r_ov;
    assign o_out.valid = r_ov;
    assign o_out.data = '{status: r_status, entry_index: r_idx,
                          entry_dest: r_odst, entry_hop: r_onh,
                          entry_cost: r_ocost, last_entry: r_olast,
                          route_changed: r_ochg, packet_changed: r_opch,
                          route_count: r_ocnt};

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;
    // output register free for the next dumped entry
    assign w_dump_step = !r_ov || w_out_acc;
    assign w_full = r_used >= CW'(TABLE_DEPTH);

    // poison change: any live entry at 1+ with dest and next hop matching
    always_comb begin
        w_pois_chg = 1'b0;
        for (int j = 1; j < TABLE_DEPTH; j++)
            if (CW'(j) < r_used && w_e[j].dest == r_dst && w_e[j].hop == r_snd)
                w_pois_chg = 1'b1;
    end

    always_comb begin
        n_st = r_st;
        w_cmd = '0;
        w_cmd.kind = CMD_NONE;
        w_wsel = r_used[IW-1:0];
        w_status = ST_OK;
        w_chg = 1'b0;
        w_used_n = r_used;
        case (r_st)
            S_IDLE: if (w_in_acc) begin
                case (i_in.data.opcode)
                    OP_ROUTE: n_st = S_SCAN;
                    OP_DUMP:  n_st = (r_used == '0) ? S_IDLE : S_DUMP;
                    default:  n_st = S_EXEC;
                endcase
            end
            S_SCAN: begin
                w_cmd.kind = CMD_SHIFT;
                if (r_cnt == CW'(TABLE_DEPTH - 1)) n_st = S_EXEC;
            end
            S_EXEC: begin
                n_st = S_OUT;
                case (r_op)
                    OP_RESET: begin
                        w_wsel = '0;
                        w_cmd.kind = CMD_WRITE;
                        w_cmd.wr_entry = '{r_my_id, r_my_id, 16'd0};
                        w_used_n = CW'(1);
                    end
                    OP_ADD: if (w_full) w_status = ST_FULL;
                    else begin
                        w_cmd.kind = CMD_WRITE;
                        w_cmd.wr_entry = '{r_dst, r_dst, (r_rc > r_inf) ? r_inf : r_rc};
                        w_used_n = r_used + 1'b1;
                    end
                    OP_DEAD: begin
                        w_cmd.kind = CMD_KILL;
                        w_cmd.match_nh = r_dst;
                        w_cmd.cost = r_inf;
                    end
                    OP_ROUTE: begin
                        if (r_dst == r_my_id) w_status = ST_IGNORED;
                        else if (!r_fi) begin
                            if (!r_fk) w_status = ST_IGNORED;
                            else if (w_full) w_status = ST_FULL;
                            else begin
                                // unknown destination: append through the sender
                                w_cmd.kind = CMD_WRITE;
                                w_cmd.wr_entry = '{r_dst, r_snd,
                                    (w_sum > {1'b0, r_inf}) ? r_inf : w_sum[15:0]};
                                w_used_n = r_used + 1'b1;
                                w_chg = 1'b1;
                            end
                        end else if (r_anh == r_my_id) begin
                            w_cmd.kind = CMD_KILL;
                            w_cmd.use_dest = 1'b1;
                            w_cmd.match_dest = r_dst;
                            w_cmd.match_nh = r_snd;
                            w_cmd.cost = r_inf;
                            w_chg = w_pois_chg;
                        end else if (r_fk && (w_nc < r_ei.cost || r_ei.hop == r_snd)) begin
                            w_wsel = r_i;
                            w_cmd.kind = CMD_WRITE;
                            w_cmd.wr_entry = '{r_ei.dest, r_snd, w_nc};
                            w_chg = (r_ei.hop != r_snd) || (r_ei.cost != w_nc);
                        end
                    end
                    default: w_status = ST_IGNORED;
                endcase
            end
            S_OUT: n_st = S_IDLE;
            S_DUMP: if (w_dump_step && r_cnt == r_dn) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= S_IDLE;
        else          r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                           r_ov <= 1'b0;
        else if (r_st == S_OUT)                 r_ov <= 1'b1;
        else if (r_st == S_DUMP && w_dump_step) r_ov <= (r_cnt != r_dn);
        else if (w_out_acc)                     r_ov <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_pflag <= 1'b0;
            r_rot   <= '0;
        end else begin
            case (r_st)
                S_IDLE: if (w_in_acc) begin
                    r_op  <= t_opcode'(i_in.data.opcode);
                    r_snd <= i_in.data.src_rtr;
                    r_lc  <= i_in.data.link_cost;
                    r_dst <= (i_in.data.opcode == OP_DEAD) ?
                             i_in.data.dead_neighbor_id : i_in.data.dest_id;
                    r_anh <= i_in.data.adv_hop;
                    r_rc  <= i_in.data.route_cost;
                    r_lastp <= i_in.data.last_of_packet;
                    r_fi <= 1'b0;
                    r_fk <= 1'b0;
                    r_cnt <= '0;
                    r_rot <= '0;
                    r_dn <= (int'(r_used) > MAX_DUMP) ? CW'(MAX_DUMP) : r_used;
                end
                S_SCAN: begin
                    // cell 0 holds entry w_head_pos before this shift
                    if (w_head_pos != '0 && CW'(w_head_pos) < r_used) begin
                        if (!r_fi && w_e[0].dest == r_dst) begin
                            r_fi <= 1'b1; r_i <= w_head_pos; r_ei <= w_e[0];
                        end
                        if (!r_fk && w_e[0].dest == r_snd) begin
                            r_fk <= 1'b1; r_ek <= w_e[0];
                        end
                    end
                    r_cnt <= r_cnt + 1'b1;
                    r_rot <= (r_cnt == CW'(TABLE_DEPTH - 1)) ? '0 : r_rot + 1'b1;
                end
                S_EXEC: begin
                    r_status <= w_status;
                    r_ochg   <= w_chg;
                    r_used   <= w_used_n;
                end
                S_OUT: begin
                    r_idx <= '0; r_odst <= '0; r_onh <= '0; r_ocost <= '0;
                    r_olast <= 1'b1;
                    r_ocnt <= 5'(r_used);
                    r_opch <= r_pflag | (r_op == OP_ROUTE && r_ochg);
                    if (r_op == OP_ROUTE)
                        r_pflag <= r_lastp ? 1'b0 : (r_pflag | r_ochg);
                end
                S_DUMP: if (w_dump_step && r_cnt != r_dn) begin
                    r_status <= ST_OK;
                    r_idx <= 4'(r_cnt);
                    r_odst <= w_e[r_cnt[IW-1:0]].dest;
                    r_onh <= w_e[r_cnt[IW-1:0]].hop;
                    r_ocost <= (w_e[r_cnt[IW-1:0]].cost > r_inf) ? r_inf :
                               w_e[r_cnt[IW-1:0]].cost;
                    r_olast <= (r_cnt + 1'b1) == r_dn;
                    r_ochg <= 1'b0;
                    r_opch <= r_pflag;
                    r_ocnt <= 5'(r_used);
                    r_cnt <= r_cnt + 1'b1;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !i_in.ready) else $error("ready while busy");
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(TABLE_DEPTH)) else $error("entries_used overflow");
    a_rot_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_IDLE) |-> (r_rot == '0)) else $error("ring not home");
`endif
endmodule
